// ===== design/rrs_pkg.sv =====
// Shared types and constants for the per-core round-robin scheduler.
package rrs_pkg;

  localparam int unsigned MaxCores     = 4;
  localparam int unsigned QueueDepth   = 16;
  localparam int unsigned BlockedDepth = 16;
  localparam int unsigned CoreW  = 2;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned AddrW  = CoreW + PosW;

  localparam logic [2:0] KIND_LOAD    = 3'd0;
  localparam logic [2:0] KIND_UNBLOCK = 3'd1;
  localparam logic [2:0] KIND_TICK    = 3'd2;
  localparam logic [2:0] KIND_BLOCK   = 3'd3;
  localparam logic [2:0] KIND_EXIT    = 3'd4;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_FULL     = 2'd1;
  localparam logic [1:0] ERR_NOTFOUND = 2'd2;

  localparam logic [2:0] REG_CORES = 3'd0;
  localparam logic [2:0] REG_QUANT0 = 3'd1;
  localparam logic [2:0] REG_QUANT3 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_APPLY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic read;
    logic apply;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

// ===== design/per_core_round_robin_scheduler.sv =====
// Each event passes through scan, queue read, update and deliver; tick and exit scan once, load scans
// one step per core in use, unblock and block walk the blocked table slot by slot, then the output waits.
// Throughput: one event at a time; the blocked-table walk sets the worst case.
// The ready-queue memory is read once per event, in its own read state.
// Reset (rst_ni low, async): cores idle, queues and blocked table empty, defaults loaded.
module per_core_round_robin_scheduler (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] task_id_i,
  input  logic [1:0] core_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] next_task_o,
  output logic       next_idle_o,
  output logic [1:0] core_used_o,
  output logic [1:0] error_o
);

  rrs_pkg::cmd_t    cmd;
  rrs_pkg::status_t status;

  rrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rrs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (kind_i),
    .task_id_i   (task_id_i),
    .core_i      (core_i),
    .next_task_o (next_task_o),
    .next_idle_o (next_idle_o),
    .core_used_o (core_used_o),
    .error_o     (error_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== design/rrs_ctrl.sv =====
// Sequencer for the scheduler: accept, scan, queue read, update, deliver.
module rrs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  rrs_pkg::status_t status_i,
  output rrs_pkg::cmd_t    cmd_o
);

  rrs_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic emit;

  assign emit = (state_q == rrs_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrs_pkg::ST_IDLE:  if (in_valid_i) state_d = rrs_pkg::ST_SCAN;
      rrs_pkg::ST_SCAN:  if (status_i.scan_last) state_d = rrs_pkg::ST_READ;
      rrs_pkg::ST_READ:  state_d = rrs_pkg::ST_APPLY;
      rrs_pkg::ST_APPLY: state_d = rrs_pkg::ST_DONE;
      rrs_pkg::ST_DONE:  if (emit) state_d = rrs_pkg::ST_IDLE;
      default:           state_d = rrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.accept = (state_q == rrs_pkg::ST_IDLE) && in_valid_i;
    cmd_o.scan   = (state_q == rrs_pkg::ST_SCAN);
    cmd_o.read   = (state_q == rrs_pkg::ST_READ);
    cmd_o.apply  = (state_q == rrs_pkg::ST_APPLY);
    cmd_o.emit   = emit;
    in_ready_o   = (state_q == rrs_pkg::ST_IDLE);
    out_valid_o  = out_valid_q;
  end

  // Hold the result beat until taken; a new one may load as the old one leaves.
  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/rrs_dp.sv =====
// Scheduler datapath: per-core state, ready queue memory, blocked table.
module rrs_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [7:0]                 cfg_wdata_i,
  input  logic [2:0]                 kind_i,
  input  logic [7:0]                 task_id_i,
  input  logic [rrs_pkg::CoreW-1:0]  core_i,
  output logic [7:0]                 next_task_o,
  output logic                       next_idle_o,
  output logic [rrs_pkg::CoreW-1:0]  core_used_o,
  output logic [1:0]                 error_o,
  input  rrs_pkg::cmd_t              cmd_i,
  output rrs_pkg::status_t           status_o
);

  localparam int unsigned NC = rrs_pkg::MaxCores;
  localparam int unsigned NB = rrs_pkg::BlockedDepth;

  // event latch
  logic [2:0] kind_q;
  logic [7:0] task_q;
  logic [rrs_pkg::CoreW-1:0] core_q;

  // configuration
  logic [2:0] cores_q;
  logic [7:0] quant_q [NC];

  // scan
  logic [rrs_pkg::SlotW-1:0] idx_q, idx_d;
  logic [rrs_pkg::CoreW-1:0] best_q, best_d;
  logic found_q, found_d;
  logic [rrs_pkg::SlotW-1:0] slot_q, slot_d;

  // per-core state
  logic [rrs_pkg::PosW-1:0]   head_q [NC], head_d [NC];
  logic [rrs_pkg::CountW-1:0] cnt_q  [NC], cnt_d  [NC];
  logic [7:0] owned_q [NC], owned_d [NC];
  logic [7:0] qleft_q [NC], qleft_d [NC];
  logic [7:0] run_q   [NC], run_d   [NC];
  logic [NC-1:0] idle_q, idle_d;

  // blocked table
  logic [NB-1:0] bv_q, bv_d;
  logic [7:0] bt_q [NB], bt_d [NB];
  logic [rrs_pkg::CoreW-1:0] bc_q [NB], bc_d [NB];

  // result
  logic [1:0] err_q, err_d;
  logic [rrs_pkg::CoreW-1:0] rep_q, rep_d;
  logic [7:0] out_task_q;
  logic out_idle_q;
  logic [rrs_pkg::CoreW-1:0] out_core_q;
  logic [1:0] out_err_q;

  // ready queue memory
  logic [7:0] mem [rrs_pkg::MaxCores * rrs_pkg::QueueDepth];
  logic [7:0] rdata_q;
  logic mem_we;
  logic [rrs_pkg::AddrW-1:0] waddr;
  logic [7:0] wdata;

  logic [2:0] n_m1;
  logic hit;
  logic [rrs_pkg::CoreW-1:0] tgt;
  logic do_dispatch;

  // Clamp the core count to 1..MaxCores, minus one.
  always_comb begin
    if (cores_q == 3'd0) n_m1 = 3'd0;
    else if (cores_q > 3'(NC)) n_m1 = 3'(NC - 1);
    else n_m1 = cores_q - 3'd1;
  end

  always_comb begin
    hit = 1'b0;
    status_o.scan_last = 1'b1;
    if (kind_q == rrs_pkg::KIND_LOAD) begin
      status_o.scan_last = (idx_q == {1'b0, n_m1});
    end else if (kind_q == rrs_pkg::KIND_UNBLOCK) begin
      hit = bv_q[idx_q] && (bt_q[idx_q] == task_q);
      status_o.scan_last = hit || (idx_q == rrs_pkg::SlotW'(NB - 1));
    end else if (kind_q == rrs_pkg::KIND_BLOCK) begin
      hit = !bv_q[idx_q];
      status_o.scan_last = hit || (idx_q == rrs_pkg::SlotW'(NB - 1));
    end
  end

  always_comb begin
    idx_d = idx_q;
    best_d = best_q;
    found_d = found_q;
    slot_d = slot_q;
    if (cmd_i.accept) begin
      idx_d = '0;
      best_d = '0;
      found_d = 1'b0;
      slot_d = '0;
    end else if (cmd_i.scan) begin
      if (kind_q == rrs_pkg::KIND_LOAD) begin
        if (owned_q[idx_q[rrs_pkg::CoreW-1:0]] < owned_q[best_q]) begin
          best_d = idx_q[rrs_pkg::CoreW-1:0];
        end
      end
      if (hit) begin
        found_d = 1'b1;
        slot_d = idx_q;
      end
      idx_d = idx_q + 1'b1;
    end
  end

  always_comb begin
    head_d = head_q;
    cnt_d = cnt_q;
    owned_d = owned_q;
    qleft_d = qleft_q;
    run_d = run_q;
    idle_d = idle_q;
    bv_d = bv_q;
    bt_d = bt_q;
    bc_d = bc_q;
    err_d = err_q;
    rep_d = rep_q;
    mem_we = 1'b0;
    waddr = '0;
    wdata = task_q;
    tgt = core_q;
    do_dispatch = 1'b0;
    if (cmd_i.apply) begin
      err_d = rrs_pkg::ERR_OK;
      rep_d = core_q;
      unique case (kind_q)
        rrs_pkg::KIND_LOAD: begin
          tgt = best_q;
          rep_d = tgt;
          if (cnt_q[tgt] < rrs_pkg::CountW'(rrs_pkg::QueueDepth)) begin
            mem_we = 1'b1;
            waddr = {tgt, head_q[tgt] + cnt_q[tgt][rrs_pkg::PosW-1:0]};
            cnt_d[tgt] = cnt_q[tgt] + 1'b1;
            if (owned_q[tgt] != 8'hFF) owned_d[tgt] = owned_q[tgt] + 8'd1;
          end else begin
            err_d = rrs_pkg::ERR_FULL;
          end
        end
        rrs_pkg::KIND_UNBLOCK: begin
          if (!found_q) begin
            err_d = rrs_pkg::ERR_NOTFOUND;
          end else begin
            tgt = bc_q[slot_q];
            rep_d = tgt;
            if (cnt_q[tgt] < rrs_pkg::CountW'(rrs_pkg::QueueDepth)) begin
              mem_we = 1'b1;
              waddr = {tgt, head_q[tgt] + cnt_q[tgt][rrs_pkg::PosW-1:0]};
              cnt_d[tgt] = cnt_q[tgt] + 1'b1;
              bv_d[slot_q] = 1'b0;
            end else begin
              err_d = rrs_pkg::ERR_FULL;
            end
          end
        end
        rrs_pkg::KIND_TICK: begin
          if (idle_q[core_q]) begin
            do_dispatch = 1'b1;
          end else if (qleft_q[core_q] <= 8'd1) begin
            // Rotate: pop the front, push the current task behind the rest.
            if (cnt_q[core_q] != '0) begin
              run_d[core_q] = rdata_q;
              mem_we = 1'b1;
              wdata = run_q[core_q];
              waddr = {core_q, head_q[core_q] + cnt_q[core_q][rrs_pkg::PosW-1:0]};
              head_d[core_q] = head_q[core_q] + 1'b1;
            end
            qleft_d[core_q] = quant_q[core_q];
          end else begin
            qleft_d[core_q] = qleft_q[core_q] - 8'd1;
          end
        end
        rrs_pkg::KIND_BLOCK: begin
          if (!idle_q[core_q]) begin
            if (found_q) begin
              bv_d[slot_q] = 1'b1;
              bt_d[slot_q] = run_q[core_q];
              bc_d[slot_q] = core_q;
            end else begin
              err_d = rrs_pkg::ERR_FULL;
            end
          end
          do_dispatch = 1'b1;
        end
        rrs_pkg::KIND_EXIT: begin
          if (owned_q[core_q] != 8'd0) owned_d[core_q] = owned_q[core_q] - 8'd1;
          do_dispatch = 1'b1;
        end
        default: begin
        end
      endcase
      if (do_dispatch) begin
        if (cnt_q[core_q] != '0) begin
          run_d[core_q] = rdata_q;
          idle_d[core_q] = 1'b0;
          head_d[core_q] = head_q[core_q] + 1'b1;
          cnt_d[core_q] = cnt_q[core_q] - 1'b1;
          qleft_d[core_q] = quant_q[core_q];
        end else begin
          idle_d[core_q] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) rdata_q <= mem[{core_q, head_q[core_q]}];
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      task_q <= task_id_i;
      core_q <= core_i;
    end
    idx_q <= idx_d;
    best_q <= best_d;
    found_q <= found_d;
    slot_q <= slot_d;
    run_q <= run_d;
    bt_q <= bt_d;
    bc_q <= bc_d;
    err_q <= err_d;
    rep_q <= rep_d;
    if (cmd_i.emit) begin
      out_task_q <= idle_q[rep_q] ? 8'd0 : run_q[rep_q];
      out_idle_q <= idle_q[rep_q];
      out_core_q <= rep_q;
      out_err_q  <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cores_q <= 3'(NC);
      for (int i = 0; i < NC; i++) begin
        quant_q[i] <= 8'd10;
        head_q[i]  <= '0;
        cnt_q[i]   <= '0;
        owned_q[i] <= '0;
        qleft_q[i] <= '0;
      end
      idle_q <= '1;
      bv_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rrs_pkg::REG_CORES) begin
          cores_q <= cfg_wdata_i[2:0];
        end else if (cfg_idx_i >= rrs_pkg::REG_QUANT0 && cfg_idx_i <= rrs_pkg::REG_QUANT3) begin
          quant_q[2'(cfg_idx_i - rrs_pkg::REG_QUANT0)] <= cfg_wdata_i;
        end
      end
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      owned_q <= owned_d;
      qleft_q <= qleft_d;
      idle_q  <= idle_d;
      bv_q    <= bv_d;
    end
  end

  assign next_task_o = out_task_q;
  assign next_idle_o = out_idle_q;
  assign core_used_o = out_core_q;
  assign error_o     = out_err_q;

endmodule

// ===== design/rrs_checker.sv =====
// Port-level checks for the scheduler, bound to the top level.
module rrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] next_task_o,
  input logic       next_idle_o,
  input logic [1:0] error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped before it was taken");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an event is in progress");

  a_idle_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && next_idle_o |-> next_task_o == 8'd0)
    else $error("idle result carries a task");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_o != 2'd3)
    else $error("undefined error code");

endmodule

bind per_core_round_robin_scheduler rrs_checker u_rrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .next_task_o (next_task_o),
  .next_idle_o (next_idle_o),
  .error_o     (error_o)
);
